// ===== src/bmpr_pkg.sv =====
// Package: shared types and constants of the battery monitor poll and reply block.
package bmpr_pkg;

  // Reply packet markers, low byte first on the wire.
  localparam logic [15:0] MK_BASE   = 16'hF0CC;
  localparam logic [15:0] MK_SWITCH = 16'hF2CC;
  localparam logic [15:0] MK_HEAT   = 16'hF3CC;
  localparam logic [15:0] MK_PROT   = 16'hF9CC;
  localparam logic [15:0] MK_NONE   = 16'h0000;

  // Query codes and their checksum bytes.
  localparam logic [7:0] CODE_HEAT    = 8'hC2;
  localparam logic [7:0] CHECK_HEAT   = 8'h46;
  localparam logic [7:0] CODE_SWITCH  = 8'hC1;
  localparam logic [7:0] CHECK_SWITCH = 8'hCE;
  localparam logic [7:0] CODE_PROT    = 8'hC4;
  localparam logic [7:0] CHECK_PROT   = 8'h4F;

  localparam logic [7:0] INTERVAL_RESET = 8'd10;

  localparam int unsigned OUT_DATA_W = 136;

  typedef enum logic [1:0] {
    ST_ISSUED  = 2'd0,
    ST_BUSY    = 2'd1,
    ST_BYTE    = 2'd2,
    ST_PKT_END = 2'd3
  } status_e;

  // Command issued by the poll sequencer.
  typedef struct packed {
    logic        issue;
    logic [7:0]  code;
    logic [7:0]  check;
    logic [15:0] exp_first;
    logic [15:0] exp_second;
  } poll_t;

  // Packet completion seen by the reply tracker.
  typedef struct packed {
    logic        done;
    logic [15:0] marker;
  } pkt_end_t;

  // Committed measurements.
  typedef struct packed {
    logic [3:0]  flags;
    logic [15:0] temperature;
    logic [15:0] cycles;
    logic [23:0] capacity;
    logic [23:0] current;
    logic [23:0] voltage;
    logic [7:0]  charge;
  } meas_t;

endpackage

// ===== src/bmpr_poll.sv =====
// Poll sequencer: poll counter and query selection.
module bmpr_poll import bmpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic       awaiting_i,
  input  logic [7:0] interval_i,
  output poll_t      poll_o
);

  logic [7:0] count_q, count_d, count_inc;

  always_comb begin
    count_inc       = count_q + 8'd1;
    count_d         = count_q;
    poll_o          = '0;
    poll_o.issue    = req_i & ~awaiting_i;
    if (count_inc < interval_i) begin
      poll_o.exp_first = MK_BASE;
      if (count_inc[0]) begin
        poll_o.code       = CODE_HEAT;
        poll_o.check      = CHECK_HEAT;
        poll_o.exp_second = MK_HEAT;
      end else begin
        poll_o.code       = CODE_SWITCH;
        poll_o.check      = CHECK_SWITCH;
        poll_o.exp_second = MK_SWITCH;
      end
      count_d = count_inc;
    end else begin
      poll_o.code       = CODE_PROT;
      poll_o.check      = CHECK_PROT;
      poll_o.exp_first  = MK_PROT;
      poll_o.exp_second = MK_NONE;
      count_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (poll_o.issue) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== src/bmpr_track.sv =====
// Reply tracker: expected markers, received packet flags and the wait flag.
module bmpr_track import bmpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  poll_t    poll_i,
  input  pkt_end_t pkt_i,
  output logic     awaiting_q_o,
  output logic     awaiting_d_o
);

  logic [15:0] exp_first_q, exp_first_d, exp_second_q, exp_second_d;
  logic        awaiting_q, awaiting_d, got_base_q, got_base_d, got_sec_q, got_sec_d;

  always_comb begin
    exp_first_d  = exp_first_q;
    exp_second_d = exp_second_q;
    awaiting_d   = awaiting_q;
    got_base_d   = got_base_q;
    got_sec_d    = got_sec_q;
    if (poll_i.issue) begin
      exp_first_d  = poll_i.exp_first;
      exp_second_d = poll_i.exp_second;
      got_base_d   = 1'b0;
      got_sec_d    = 1'b0;
      awaiting_d   = 1'b1;
    end else if (pkt_i.done) begin
      if (exp_second_q != MK_NONE) begin
        if (pkt_i.marker == exp_first_q) begin
          got_base_d = 1'b1;
        end else if (pkt_i.marker == exp_second_q) begin
          got_sec_d = 1'b1;
        end
        if (got_base_d && got_sec_d) begin
          awaiting_d = 1'b0;
          got_base_d = 1'b0;
          got_sec_d  = 1'b0;
        end
      end else if (pkt_i.marker == exp_first_q) begin
        awaiting_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_first_q  <= '0;
      exp_second_q <= '0;
      awaiting_q   <= 1'b0;
      got_base_q   <= 1'b0;
      got_sec_q    <= 1'b0;
    end else if (step_i) begin
      exp_first_q  <= exp_first_d;
      exp_second_q <= exp_second_d;
      awaiting_q   <= awaiting_d;
      got_base_q   <= got_base_d;
      got_sec_q    <= got_sec_d;
    end
  end

  assign awaiting_q_o = awaiting_q;
  assign awaiting_d_o = awaiting_d;

endmodule

// ===== src/bmpr_rx.sv =====
// Reply decoder: byte position, packet staging and committed measurements.
module bmpr_rx import bmpr_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     byte_en_i,
  input  logic [7:0] byte_i,
  input  logic     last_i,
  output pkt_end_t pkt_o,
  output meas_t    meas_d_o
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   mk_q, mk_d;
  logic [23:0]   st0_q, st0_d, st1_q, st1_d, st2_q, st2_d;
  logic [15:0]   st3_q, st3_d, st5_q, st5_d;
  logic [7:0]    st4_q, st4_d;
  logic          acc_q, acc_d;
  meas_t         meas_q, meas_d;

  always_comb begin
    logic start;
    start = (pos_q == '0);
    pos_d = pos_q;
    mk_d  = start ? '0 : mk_q;
    st0_d = start ? '0 : st0_q;
    st1_d = start ? '0 : st1_q;
    st2_d = start ? '0 : st2_q;
    st3_d = start ? '0 : st3_q;
    st4_d = start ? '0 : st4_q;
    st5_d = start ? '0 : st5_q;
    acc_d = start ? 1'b0 : acc_q;
    if (pos_q < PW'(MAX_PACKET_BYTES)) begin
      pos_d = pos_q + PW'(1);
      if (pos_q == PW'(0)) begin
        mk_d = {8'h00, byte_i};
      end else if (pos_q == PW'(1)) begin
        mk_d[15:8] = byte_i;
      end else begin
        unique case (mk_d)
          MK_BASE: begin
            if (pos_q == PW'(2))  st0_d[7:0]   = byte_i;
            if (pos_q == PW'(3))  st0_d[15:8]  = byte_i;
            if (pos_q == PW'(4))  st0_d[23:16] = byte_i;
            if (pos_q == PW'(5))  st1_d[7:0]   = byte_i;
            if (pos_q == PW'(6))  st1_d[15:8]  = byte_i;
            if (pos_q == PW'(7))  st1_d[23:16] = byte_i;
            if (pos_q == PW'(11)) st2_d[7:0]   = byte_i;
            if (pos_q == PW'(12)) st2_d[15:8]  = byte_i;
            if (pos_q == PW'(13)) st2_d[23:16] = byte_i;
            if (pos_q == PW'(14)) st3_d[7:0]   = byte_i;
            if (pos_q == PW'(15)) st3_d[15:8]  = byte_i;
            if (pos_q == PW'(16)) st4_d        = byte_i;
          end
          MK_SWITCH: begin
            if (pos_q == PW'(2)) st0_d[7:0]  = byte_i;
            if (pos_q == PW'(3)) st1_d[7:0]  = byte_i;
            if (pos_q == PW'(5)) st5_d[7:0]  = byte_i;
            if (pos_q == PW'(6)) st5_d[15:8] = byte_i;
          end
          MK_HEAT: begin
            if (pos_q == PW'(8)) st0_d[7:0] = byte_i;
          end
          MK_PROT: begin
            if (pos_q <= PW'(16) && byte_i != 8'h00) acc_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (last_i) pos_d = '0;
  end

  // Commit at packet end from the staging contents including this byte. A poll never
  // commits, whatever its last bit says.
  always_comb begin
    meas_d = meas_q;
    if (byte_en_i && last_i) begin
      unique case (mk_d)
        MK_BASE: begin
          meas_d.voltage  = st0_d;
          meas_d.current  = st1_d;
          meas_d.capacity = st2_d;
          meas_d.cycles   = st3_d;
          meas_d.charge   = st4_d;
        end
        MK_SWITCH: begin
          meas_d.flags[0]    = (st0_d != '0);
          meas_d.flags[1]    = (st1_d != '0);
          meas_d.temperature = st5_d;
        end
        MK_HEAT:  meas_d.flags[2] = (st0_d != '0);
        MK_PROT:  meas_d.flags[3] = acc_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mk_q   <= '0;
      acc_q  <= 1'b0;
      meas_q <= '0;
    end else if (byte_en_i) begin
      pos_q  <= pos_d;
      mk_q   <= mk_d;
      acc_q  <= acc_d;
      meas_q <= meas_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en_i) begin
      st0_q <= st0_d;
      st1_q <= st1_d;
      st2_q <= st2_d;
      st3_q <= st3_d;
      st4_q <= st4_d;
      st5_q <= st5_d;
    end
  end

  assign pkt_o.done   = byte_en_i & last_i;
  assign pkt_o.marker = mk_d;
  assign meas_d_o     = meas_d;

endmodule

// ===== src/battery_monitor_poll_and_response.sv =====
// Top level: battery monitor poll sequencer and reply decoder with stream ports.
//
//  Channel   Direction  Handshake                       Content
//  s_axis    in         s_axis_tvalid / s_axis_tready   poll request or one reply byte
//  m_axis    out        m_axis_tvalid / m_axis_tready   status, issued frame, measurements
//  cfg       in         cfg_valid_i / cfg_ready_o       protection interval register
//
// Each input transaction is captured in an input register and processed, once the
// result register is free or being emptied, by a single pass of combinational logic,
// which updates the state and loads the result register. One transaction per cycle is
// sustained while m_axis does not stall. A stall on m_axis holds the result register
// and, through it, the input register, so neither side loses data. Reset clears all
// control state and the committed measurements; the interval register returns to ten.
// The configuration port is always ready.
module battery_monitor_poll_and_response import bmpr_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  input  logic                  s_axis_tlast,   // rx_last
  input  logic [0:0]            s_axis_tuser,   // [0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] tx_code, [15:8] tx_check, [16] awaiting, [24:17] charge_percent,
  // [48:25] voltage_mv, [72:49] current_ma, [96:73] capacity_mah,
  // [112:97] cycle_count, [128:113] temperature, [132:129] pack_flags, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i      // protection_interval
);

  logic       in_valid_q, in_cmd_q, in_last_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  status_e    out_status_q, status_d;
  logic [7:0] interval_q;
  logic       step;
  logic       awaiting_q, awaiting_d;
  poll_t      poll;
  pkt_end_t   pkt;
  meas_t      meas_d;

  // The pass completes whenever the result register is free or being emptied.
  assign step          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  bmpr_poll u_poll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (step & ~in_cmd_q),
    .awaiting_i (awaiting_q),
    .interval_i (interval_q),
    .poll_o     (poll)
  );

  bmpr_rx #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (step & in_cmd_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .pkt_o     (pkt),
    .meas_d_o  (meas_d)
  );

  bmpr_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .poll_i       (poll),
    .pkt_i        (pkt),
    .awaiting_q_o (awaiting_q),
    .awaiting_d_o (awaiting_d)
  );

  // Result assembly. Frame bytes are zero unless a command is actually issued.
  always_comb begin
    logic [7:0] code, check;
    code  = poll.issue ? poll.code  : 8'h00;
    check = poll.issue ? poll.check : 8'h00;
    if (!in_cmd_q) begin
      status_d = awaiting_q ? ST_BUSY : ST_ISSUED;
    end else begin
      status_d = in_last_q ? ST_PKT_END : ST_BYTE;
    end
    out_data_d = {3'b000, meas_d.flags, meas_d.temperature, meas_d.cycles,
                  meas_d.capacity, meas_d.current, meas_d.voltage, meas_d.charge,
                  awaiting_d, check, code};
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q   <= out_data_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule
